### rtl/fed_pkg.sv
// Shared types and constants of the flight event detector.
`default_nettype none

package fed_pkg;

	// Flight phase codes as they appear on the result port
	localparam logic [1:0] PH_ARMED   = 2'd0;
	localparam logic [1:0] PH_ASCENT  = 2'd1;
	localparam logic [1:0] PH_APOGEE  = 2'd2;
	localparam logic [1:0] PH_DESCENT = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_LAUNCH_THR  = 2'd0;
	localparam logic [1:0] CFG_LAUNCH_HOLD = 2'd1;
	localparam logic [1:0] CFG_APOGEE_HOLD = 2'd2;

	// Register reset values
	localparam logic [15:0] LAUNCH_THR_RST  = 16'd3000;
	localparam logic [15:0] LAUNCH_HOLD_RST = 16'd100;
	localparam logic [15:0] APOGEE_HOLD_RST = 16'd500;

	// Peak altitude before launch: most negative altitude
	localparam logic signed [23:0] PEAK_RST = 24'sh800000;

	// One sample as seen by the phase logic
	typedef struct packed {
		logic               thrust;
		logic               baro_ok;
		logic signed [23:0] altitude_cm;
		logic [31:0]        time_ms;
	} sample_t;

	// Hold times from the configuration registers
	typedef struct packed {
		logic [15:0] thrust_dwell_ms;
		logic [15:0] fall_dwell_ms;
	} hold_cfg_t;

	// One result beat
	typedef struct packed {
		logic [1:0] phase;
		logic       guidance_on;
		logic       launch_seen;
		logic       apogee_seen;
	} result_t;

endpackage

`default_nettype wire

### rtl/fed_phase_fsm.sv
// Flight phase sequencer: thrust and fall timers, peak altitude, guidance flag.
`default_nettype none

module fed_phase_fsm
	import fed_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      advance,
	input  wire sample_t   sample,
	input  wire hold_cfg_t hold_cfg,
	output result_t        result
);

	typedef enum logic [1:0] {
		ARMED   = PH_ARMED,
		ASCENT  = PH_ASCENT,
		APOGEE  = PH_APOGEE,
		DESCENT = PH_DESCENT
	} phase_t;

	phase_t             phase_q, phase_d;
	logic               thrust_run_q, thrust_run_d;
	logic [31:0]        thrust_start_q, thrust_start_d;
	logic               fall_run_q, fall_run_d;
	logic [31:0]        fall_start_q, fall_start_d;
	logic signed [23:0] peak_q, peak_d;
	logic               guid_q, guid_d;
	logic               launch_d, apogee_d;
	logic [31:0]        thrust_age, fall_age;

	// Elapsed times wrap modulo 2^32
	assign thrust_age = sample.time_ms - thrust_start_q;
	assign fall_age   = sample.time_ms - fall_start_q;

	// Next state for the sample at the head of the pipe
	always_comb begin
		phase_d        = phase_q;
		thrust_run_d   = thrust_run_q;
		thrust_start_d = thrust_start_q;
		fall_run_d     = fall_run_q;
		fall_start_d   = fall_start_q;
		peak_d         = peak_q;
		guid_d         = guid_q;
		launch_d       = 1'b0;
		apogee_d       = 1'b0;
		case (phase_q)
			ARMED: begin
				if (!sample.thrust) begin
					thrust_run_d = 1'b0;
				end else if (!thrust_run_q) begin
					thrust_run_d   = 1'b1;
					thrust_start_d = sample.time_ms;
				end else if (thrust_age >= {16'd0, hold_cfg.thrust_dwell_ms}) begin
					phase_d  = ASCENT;
					guid_d   = 1'b1;
					peak_d   = sample.altitude_cm;
					launch_d = 1'b1;
				end
			end
			ASCENT: begin
				// Ignore samples with an unhealthy barometer
				if (sample.baro_ok) begin
					if (sample.altitude_cm > peak_q) begin
						peak_d     = sample.altitude_cm;
						fall_run_d = 1'b0;
					end else if (!fall_run_q) begin
						fall_run_d   = 1'b1;
						fall_start_d = sample.time_ms;
					end else if (fall_age >= {16'd0, hold_cfg.fall_dwell_ms}) begin
						phase_d  = APOGEE;
						guid_d   = 1'b0;
						apogee_d = 1'b1;
					end
				end
			end
			APOGEE: begin
				phase_d = DESCENT;
			end
			DESCENT: begin
				phase_d = DESCENT;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// Hold state; advance only when the sample moves on to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= ARMED;
			thrust_run_q   <= 1'b0;
			thrust_start_q <= '0;
			fall_run_q     <= 1'b0;
			fall_start_q   <= '0;
			peak_q         <= PEAK_RST;
			guid_q         <= 1'b0;
		end else if (advance) begin
			phase_q        <= phase_d;
			thrust_run_q   <= thrust_run_d;
			thrust_start_q <= thrust_start_d;
			fall_run_q     <= fall_run_d;
			fall_start_q   <= fall_start_d;
			peak_q         <= peak_d;
			guid_q         <= guid_d;
		end
	end

	assign result.phase       = phase_d;
	assign result.guidance_on = guid_d;
	assign result.launch_seen = launch_d;
	assign result.apogee_seen = apogee_d;

endmodule

`default_nettype wire

### rtl/flight_event_detector_unit.sv
// Top level of the flight event detector: handshake pipe, magnitude test, registers.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | sink      | in_valid / in_ready  | accel_x/y/z, altitude_cm, baro_ok, time_ms
//  out     | source    | out_valid / out_ready| phase, guidance_on, launch_seen, apogee_seen
//  cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One sample per clock is sustained while out_ready stays high; each sample passes from input
// beat to result beat through the input register, squared axes and result register.
// The phase state updates as a sample enters the result register, so the
// sample order through the single phase sequencer sets the rate of one per clock.
// Each stage has its own valid bit and fills while the result waits, so up to
// two more samples are taken during an output stall.
// Reset restores armed phase and the register defaults; cfg_ready is always high.
`default_nettype none

module flight_event_detector_unit
	import fed_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	input  wire logic signed [23:0] altitude_cm,
	input  wire logic               baro_ok,
	input  wire logic [31:0]        time_ms,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              phase,
	output logic                    guidance_on,
	output logic                    launch_seen,
	output logic                    apogee_seen,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);

	// Configuration registers; the threshold is kept squared
	logic [31:0] thr_sq_q;
	hold_cfg_t   hold_q;

	// Stage 1: input register
	logic               v_s1;
	logic signed [15:0] ax_s1, ay_s1, az_s1;
	logic signed [23:0] alt_s1;
	logic               ok_s1;
	logic [31:0]        time_s1;

	// Stage 2: squared axes
	logic               v_s2;
	logic [30:0]        sqx_s2, sqy_s2, sqz_s2;
	logic signed [23:0] alt_s2;
	logic               ok_s2;
	logic [31:0]        time_s2;

	// Result register
	logic    out_valid_q;
	result_t res_q;

	logic        rdy_s1, rdy_s2, rdy_out;
	logic        adv_s2;
	logic signed [31:0] px, py, pz;
	logic [31:0] mag_sq;
	sample_t     sample;
	result_t     res_d;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_sq_q               <= {16'd0, LAUNCH_THR_RST} * {16'd0, LAUNCH_THR_RST};
			hold_q.thrust_dwell_ms <= LAUNCH_HOLD_RST;
			hold_q.fall_dwell_ms   <= APOGEE_HOLD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LAUNCH_THR:  thr_sq_q <= {16'd0, cfg_data} * {16'd0, cfg_data};
				CFG_LAUNCH_HOLD: hold_q.thrust_dwell_ms <= cfg_data;
				CFG_APOGEE_HOLD: hold_q.fall_dwell_ms   <= cfg_data;
				default:         thr_sq_q <= thr_sq_q;
			endcase
		end
	end

	// Stage readiness: a stage moves when empty or when its successor moves
	assign rdy_out  = !out_valid_q || out_ready;
	assign rdy_s2   = !v_s2 || rdy_out;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign adv_s2   = v_s2 && rdy_out;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_out) out_valid_q <= v_s2;
		end
	end

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			ax_s1   <= accel_x;
			ay_s1   <= accel_y;
			az_s1   <= accel_z;
			alt_s1  <= altitude_cm;
			ok_s1   <= baro_ok;
			time_s1 <= time_ms;
		end
	end

	// Square each axis; every square is non-negative and at most 2^30
	assign px = ax_s1 * ax_s1;
	assign py = ay_s1 * ay_s1;
	assign pz = az_s1 * az_s1;

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			sqx_s2  <= px[30:0];
			sqy_s2  <= py[30:0];
			sqz_s2  <= pz[30:0];
			alt_s2  <= alt_s1;
			ok_s2   <= ok_s1;
			time_s2 <= time_s1;
		end
	end

	// Sum of squares fits in 32 bits; compare with the squared threshold
	assign mag_sq = {1'b0, sqx_s2} + {1'b0, sqy_s2} + {1'b0, sqz_s2};

	assign sample.thrust      = (mag_sq >= thr_sq_q);
	assign sample.baro_ok     = ok_s2;
	assign sample.altitude_cm = alt_s2;
	assign sample.time_ms     = time_s2;

	fed_phase_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (adv_s2),
		.sample   (sample),
		.hold_cfg (hold_q),
		.result   (res_d)
	);

	// Load the result register
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_q <= res_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign phase       = res_q.phase;
	assign guidance_on = res_q.guidance_on;
	assign launch_seen = res_q.launch_seen;
	assign apogee_seen = res_q.apogee_seen;

endmodule

`default_nettype wire

### rtl/fed_checker.sv
// Port-level checks on the flight event detector and their bind.
`default_nettype none

module fed_checker
	import fed_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] phase,
	input wire logic       guidance_on,
	input wire logic       launch_seen,
	input wire logic       apogee_seen
);

	// Never both events on one beat
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(launch_seen && apogee_seen))
		else $error("launch and apogee on the same beat");

	// Launch lands in ascent with guidance on
	a_launch_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && launch_seen |-> phase == PH_ASCENT && guidance_on)
		else $error("launch beat not in ascent with guidance");

	// Apogee lands in apogee phase with guidance off
	a_apogee_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && apogee_seen |-> phase == PH_APOGEE && !guidance_on)
		else $error("apogee beat not in apogee phase");

	// Guidance is on exactly during ascent
	a_guidance: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> guidance_on == (phase == PH_ASCENT))
		else $error("guidance flag disagrees with phase");

	// A stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phase)
			&& $stable(guidance_on) && $stable(launch_seen) && $stable(apogee_seen))
		else $error("stalled result beat changed");

endmodule

bind flight_event_detector_unit fed_checker u_fed_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.phase       (phase),
	.guidance_on (guidance_on),
	.launch_seen (launch_seen),
	.apogee_seen (apogee_seen)
);

`default_nettype wire

### test/testbench.sv
// Self-checking bench for the flight event detector: planned sensor beats against a phase predictor.

module testbench;
	import fed_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	// One sensor beat as the bench plans and predicts it
	typedef struct {
		logic signed [15:0] ax, ay, az;
		logic signed [23:0] alt;
		logic               ok;
		logic [31:0]        ms;
	} sensor_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [15:0] accel_x = '0;
	logic signed [15:0] accel_y = '0;
	logic signed [15:0] accel_z = '0;
	logic signed [23:0] altitude_cm = '0;
	logic               baro_ok = 1'b0;
	logic [31:0]        time_ms = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         phase;
	logic               guidance_on;
	logic               launch_seen;
	logic               apogee_seen;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = CFG_LAUNCH_THR;
	logic [15:0]        cfg_data = '0;

	flight_event_detector_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.altitude_cm(altitude_cm), .baro_ok(baro_ok), .time_ms(time_ms),
		.out_valid(out_valid), .out_ready(out_ready),
		.phase(phase), .guidance_on(guidance_on),
		.launch_seen(launch_seen), .apogee_seen(apogee_seen),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor copy of the registers and the flight state
	logic [15:0]        thr_mg = LAUNCH_THR_RST;
	logic [15:0]        launch_hold = LAUNCH_HOLD_RST;
	logic [15:0]        apogee_hold = APOGEE_HOLD_RST;
	logic [1:0]         flight_ph = PH_ARMED;
	logic               thrust_on = 1'b0;
	logic [31:0]        thrust_t0 = '0;
	logic               fall_on = 1'b0;
	logic [31:0]        fall_t0 = '0;
	logic signed [23:0] peak_cm = PEAK_RST;
	logic               guiding = 1'b0;

	// Stimulus planner's view of the timers, kept ahead of the predictor
	logic [31:0]        gen_ms = '0;
	logic               plan_thrust = 1'b0;
	logic [31:0]        plan_t0 = '0;
	logic               plan_fall = 1'b0;
	logic [31:0]        plan_f0 = '0;
	int                 plan_peak = 0;

	sensor_beat_t pending_samples[$];
	result_t      due_status[$];
	int           beats_sent = 0;
	int           beats_seen = 0;
	int           mismatches = 0;
	int           cycles = 0;

	always #5 clk = ~clk;

	task automatic flag(string what);
		if (mismatches < 50)
			$display("MISMATCH cycle %0d: %s", cycles, what);
		mismatches++;
	endtask

	function automatic longint mag_sq(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z);
		return longint'(x) * x + longint'(y) * y + longint'(z) * z;
	endfunction

	// Squared magnitude against squared threshold, no root taken
	function automatic logic is_thrust(sensor_beat_t s);
		return mag_sq(s.ax, s.ay, s.az) >= longint'(thr_mg) * longint'(thr_mg);
	endfunction

	// Advance the flight state by one beat and return the status it produces
	function automatic result_t advance_flight(sensor_beat_t s);
		result_t     r;
		logic [31:0] dt;
		r = '0;
		case (flight_ph)
			PH_ARMED: begin
				dt = s.ms - thrust_t0;
				if (!is_thrust(s)) begin
					thrust_on = 1'b0;
				end else if (!thrust_on) begin
					thrust_on = 1'b1;
					thrust_t0 = s.ms;
				end else if (dt >= launch_hold) begin
					r.launch_seen = 1'b1;
					flight_ph = PH_ASCENT;
					guiding = 1'b1;
					peak_cm = s.alt;
				end
			end
			PH_ASCENT: begin
				dt = s.ms - fall_t0;
				// an unhealthy barometer leaves peak and timer alone
				if (s.ok) begin
					if (s.alt > peak_cm) begin
						peak_cm = s.alt;
						fall_on = 1'b0;
					end else if (!fall_on) begin
						fall_on = 1'b1;
						fall_t0 = s.ms;
					end else if (dt >= apogee_hold) begin
						r.apogee_seen = 1'b1;
						flight_ph = PH_APOGEE;
						guiding = 1'b0;
					end
				end
			end
			PH_APOGEE: flight_ph = PH_DESCENT;
			default: ;
		endcase
		r.phase = flight_ph;
		r.guidance_on = guiding;
		return r;
	endfunction

	function automatic logic signed [15:0] corner_axis();
		case ($urandom_range(3))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			default: return 16'shFFFF;
		endcase
	endfunction

	function automatic sensor_beat_t noise_beat();
		sensor_beat_t s;
		{s.ax, s.ay, s.az} = 48'({$urandom, $urandom});
		s.alt = 24'($urandom);
		s.ok = 1'($urandom);
		s.ms = $urandom;
		return s;
	endfunction

	// Shape the acceleration: wild, under threshold, at the threshold edge, or corners
	function automatic sensor_beat_t with_accel(sensor_beat_t s);
		int h;
		int lvl;
		h = int'(thr_mg) / 2;
		lvl = int'(thr_mg) + int'($urandom_range(2)) - 1;
		case ($urandom_range(3))
			0: ;
			1: begin
				s.ax = 16'(int'($urandom_range(2 * h)) - h);
				s.ay = 16'(int'($urandom_range(2 * h)) - h);
				s.az = 16'(int'($urandom_range(2 * h)) - h);
			end
			2: if (thr_mg <= 16'd32766) begin
				s.ax = 16'(($urandom_range(1) != 0) ? lvl : -lvl);
				s.ay = '0;
				s.az = '0;
			end
			default: begin
				s.ax = corner_axis();
				s.ay = corner_axis();
				s.az = corner_axis();
			end
		endcase
		return s;
	endfunction

	// Pick a timestamp with no running timer to respect
	function automatic logic [31:0] free_ms();
		case ($urandom_range(7))
			0: gen_ms = $urandom;
			1: gen_ms = 32'hFFFF_FFFF - $urandom_range(300);
			default: gen_ms = gen_ms + $urandom_range(50);
		endcase
		return gen_ms;
	endfunction

	// Pick a timestamp that stays short of the hold time, often by one
	function automatic logic [31:0] held_ms(logic [31:0] t0, logic [15:0] hold);
		int unsigned span;
		span = {16'd0, hold};
		span = span - 1;
		gen_ms = t0 + (($urandom_range(3) == 0) ? span : $urandom_range(span));
		return gen_ms;
	endfunction

	task automatic queue_beat(int ax, int ay, int az, int alt, logic ok, logic [31:0] ms);
		sensor_beat_t s;
		s.ax = 16'(ax);
		s.ay = 16'(ay);
		s.az = 16'(az);
		s.alt = 24'(alt);
		s.ok = ok;
		s.ms = ms;
		pending_samples.push_back(s);
	endtask

	// Armed beats: thrust runs always end before the launch hold time
	task automatic fly_armed(int n);
		sensor_beat_t s;
		repeat (n) begin
			s = with_accel(noise_beat());
			if (!is_thrust(s)) begin
				plan_thrust = 1'b0;
				s.ms = free_ms();
			end else if (plan_thrust) begin
				s.ms = held_ms(plan_t0, launch_hold);
			end else begin
				plan_thrust = 1'b1;
				s.ms = free_ms();
				plan_t0 = s.ms;
			end
			pending_samples.push_back(s);
		end
	endtask

	// Ascent beats: climbs, level and falling readings, bad barometer; no apogee
	task automatic fly_ascent(int n);
		sensor_beat_t s;
		repeat (n) begin
			s = with_accel(noise_beat());
			s.ok = $urandom_range(4) != 0;
			if (s.ok) begin
				if (plan_peak < 8388000 && $urandom_range(3) == 0) begin
					plan_peak += int'($urandom_range(500, 1));
					s.alt = 24'(plan_peak);
					plan_fall = 1'b0;
					s.ms = free_ms();
				end else begin
					case ($urandom_range(3))
						0: s.alt = 24'(plan_peak);
						1: s.alt = PEAK_RST;
						default: s.alt = 24'(plan_peak - int'($urandom_range(2000)));
					endcase
					if (plan_fall) begin
						s.ms = held_ms(plan_f0, apogee_hold);
					end else begin
						plan_fall = 1'b1;
						s.ms = free_ms();
						plan_f0 = s.ms;
					end
				end
			end
			pending_samples.push_back(s);
		end
	endtask

	task automatic drain_flight();
		do @(negedge clk);
		while (pending_samples.size() != 0 || in_valid || due_status.size() != 0);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_LAUNCH_THR: thr_mg = val;
			CFG_LAUNCH_HOLD: launch_hold = val;
			CFG_APOGEE_HOLD: apogee_hold = val;
			default: ;
		endcase
	endtask

	task automatic check_field(string name, logic [1:0] got, logic [1:0] want);
		if (got !== want)
			flag($sformatf("status beat %0d: %s is %0d, want %0d", beats_seen, name, got, want));
	endtask

	// Drive sensor beats: hold each until taken, then predict its status
	always @(posedge clk or negedge arst_n) begin
		sensor_beat_t s;
		int idle_pct;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				s.ax = accel_x;
				s.ay = accel_y;
				s.az = accel_z;
				s.alt = altitude_cm;
				s.ok = baro_ok;
				s.ms = time_ms;
				due_status.push_back(advance_flight(s));
			end
			idle_pct = (beats_sent < 640) ? 11 : (beats_sent < 1280) ? 79 : 0;
			if (!in_valid || in_ready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
					s = pending_samples.pop_front();
					accel_x <= s.ax;
					accel_y <= s.ay;
					accel_z <= s.az;
					altitude_cm <= s.alt;
					baro_ok <= s.ok;
					time_ms <= s.ms;
					in_valid <= 1'b1;
					beats_sent++;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Take status beats and compare them with the oldest one due
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		int idle_pct;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				beats_seen++;
				if (due_status.size() == 0) begin
					flag($sformatf("status beat %0d arrived with nothing due", beats_seen));
				end else begin
					want = due_status.pop_front();
					check_field("phase", phase, want.phase);
					check_field("guidance_on", guidance_on, want.guidance_on);
					check_field("launch_seen", launch_seen, want.launch_seen);
					check_field("apogee_seen", apogee_seen, want.apogee_seen);
				end
			end
			idle_pct = (beats_seen < 640) ? 79 : (beats_seen < 1280) ? 11 : 0;
			out_ready <= $urandom_range(99) >= idle_pct;
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int base_ms;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Armed at reset settings: exact threshold, thrust lost, hold edge across wrap
		queue_beat(0, 0, 0, 0, 1'b1, 32'd0);
		queue_beat(3000, 0, 0, 1000, 1'b0, 32'd16);
		queue_beat(2999, 0, 0, -1000, 1'b1, 32'd40);
		queue_beat(0, 1800, 2400, 8388607, 1'b1, 32'd100);
		queue_beat(0, 0, -3000, -8388608, 1'b0, 32'd199);
		queue_beat(1732, 1732, 1732, 5, 1'b1, 32'd500);
		queue_beat(1733, -1733, 1733, 0, 1'b1, 32'hFFFF_FFC0);
		queue_beat(-32768, -32768, -32768, -1, 1'b0, 32'h0000_0023);
		queue_beat(32767, 32767, 32767, 100, 1'b1, 32'hFFFF_FFFF);
		queue_beat(-1, 1, 0, 0, 1'b0, 32'h0000_0024);
		gen_ms = 32'h0000_0024;
		drain_flight();

		// Armed at the threshold extremes, longest hold
		set_reg(CFG_LAUNCH_HOLD, 16'hFFFF);
		set_reg(CFG_LAUNCH_THR, 16'd0);
		fly_armed(150);
		drain_flight();
		set_reg(CFG_LAUNCH_THR, 16'd56756);
		fly_armed(150);
		drain_flight();
		set_reg(CFG_LAUNCH_THR, 16'd56755);
		fly_armed(50);
		drain_flight();

		// Armed at assorted settings
		repeat (4) begin
			set_reg(CFG_LAUNCH_THR, 16'($urandom_range(6000, 200)));
			set_reg(CFG_LAUNCH_HOLD, 16'($urandom_range(2000, 1)));
			fly_armed(120);
			drain_flight();
		end

		// Launch with zero hold: the beat that starts the timer must not launch
		set_reg(CFG_LAUNCH_THR, 16'($urandom_range(20000, 500)));
		set_reg(CFG_LAUNCH_HOLD, 16'd0);
		queue_beat(0, 0, 0, $urandom, 1'b1, free_ms());
		queue_beat(-32768, -32768, -32768, $urandom, 1'b0, free_ms());
		plan_peak = int'($urandom_range(2000)) - 1000;
		queue_beat(32767, -32768, 32767, plan_peak, 1'b1, $urandom);
		plan_fall = 1'b0;
		drain_flight();

		// Ascent: bad barometer ignored, hold edge, new peak stops the fall timer
		set_reg(CFG_APOGEE_HOLD, 16'd300);
		base_ms = $urandom;
		queue_beat(32767, 32767, 32767, 8388607, 1'b0, $urandom);
		queue_beat(0, 0, 0, plan_peak, 1'b1, base_ms);
		queue_beat(0, 0, 0, plan_peak - 1, 1'b1, base_ms + 299);
		queue_beat(0, 0, 0, -8388608, 1'b0, base_ms + 5000);
		plan_peak++;
		queue_beat(0, 0, 0, plan_peak, 1'b1, base_ms + 6000);
		gen_ms = base_ms + 6000;
		drain_flight();

		// Ascent random, launch threshold changes have no effect here
		set_reg(CFG_APOGEE_HOLD, 16'hFFFF);
		fly_ascent(200);
		drain_flight();
		set_reg(CFG_LAUNCH_THR, 16'd0);
		repeat (5) begin
			set_reg(CFG_APOGEE_HOLD, 16'($urandom_range(3000, 1)));
			fly_ascent(170);
			drain_flight();
		end

		// Apogee with zero hold, then descent ignores everything
		set_reg(CFG_APOGEE_HOLD, 16'd0);
		plan_peak++;
		queue_beat(0, 0, 0, plan_peak, 1'b1, free_ms());
		queue_beat(0, 0, 0, plan_peak, 1'b1, free_ms());
		queue_beat(0, 0, 0, plan_peak - 1, 1'b1, $urandom);
		repeat (21) pending_samples.push_back(noise_beat());
		drain_flight();

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
